// File: rtl/sfa_pkg.sv
// Shared types and constants of the segment fit allocator.
`timescale 1ns / 1ps
`default_nettype none
package sfa_pkg;

   localparam int SLOT_W    = 4;
   localparam int AMT_W     = 16;
   localparam int TOTAL_W   = 20;
   localparam int MODE_W    = 2;
   localparam int CNT_CFG_W = 5;
   localparam int ADDR_W    = 1;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 40;

   localparam logic [TOTAL_W-1:0]   TOTAL_MAX      = '1;
   localparam logic [CNT_CFG_W-1:0] SLOTS_IN_USE_RST = 5'd16;

   // register indexes
   localparam logic [ADDR_W-1:0] CSR_FIT_MODE     = 1'b0;
   localparam logic [ADDR_W-1:0] CSR_SLOTS_IN_USE = 1'b1;

   // item kinds
   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_ALLOC = 1'b1;

   // placement policies; the unused code behaves as first fit
   localparam logic [MODE_W-1:0] FIT_FIRST = 2'd0;
   localparam logic [MODE_W-1:0] FIT_BEST  = 2'd1;
   localparam logic [MODE_W-1:0] FIT_WORST = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LAUNCH,
      ST_SCAN,
      ST_APPLY
   } state_type;

   // broadcast command from the sequencer to every cell
   typedef struct packed {
      logic load_en;
      logic sub_en;
   } cell_cmd_type;

endpackage
`default_nettype wire

// File: rtl/sfa_cell.sv
// One segment cell: holds a free size and updates the passing scan record.
`timescale 1ns / 1ps
`default_nettype none
module sfa_cell #(
   parameter int SIZE_BITS = 16,
   parameter int IDX_W     = 4,
   parameter int TGT_W     = 4,
   parameter int CNT_W     = 5,
   parameter int ACC_W     = 21,
   parameter int CELL_IDX  = 0
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire sfa_pkg::cell_cmd_type   cmd,
   input  wire  [TGT_W-1:0]             tgt,
   input  wire  [SIZE_BITS-1:0]         amt,
   input  wire  [sfa_pkg::MODE_W-1:0]   mode,
   input  wire  [CNT_W-1:0]             count,
   input  wire                          vld_in,
   input  wire                          found_in,
   input  wire  [IDX_W-1:0]             idx_in,
   input  wire  [SIZE_BITS-1:0]         val_in,
   input  wire  [ACC_W-1:0]             sum_in,
   output logic                         vld_out,
   output logic                         found_out,
   output logic [IDX_W-1:0]             idx_out,
   output logic [SIZE_BITS-1:0]         val_out,
   output logic [ACC_W-1:0]             sum_out
);
   import sfa_pkg::*;

   logic [SIZE_BITS-1:0] seg_ff, seg_in;
   logic                 vld_ff, vld_in_nxt;
   logic                 found_ff, found_in_nxt;
   logic [IDX_W-1:0]     idx_ff, idx_in_nxt;
   logic [SIZE_BITS-1:0] val_ff, val_in_nxt;
   logic [ACC_W-1:0]     sum_ff, sum_in_nxt;
   logic                 in_use, fits, better, take, hit;

   assign in_use = CNT_W'(CELL_IDX) < count;
   assign fits   = in_use && (seg_ff >= amt);
   assign hit    = tgt == TGT_W'(CELL_IDX);

   always_comb begin
      case (mode)
         FIT_BEST:  better = seg_ff < val_in;
         FIT_WORST: better = seg_ff > val_in;
         default:   better = 1'b0;
      endcase
      take = fits && (!found_in || better);
   end

   always_comb begin
      seg_in = seg_ff;
      if (cmd.load_en && hit) begin
         seg_in = amt;
      end else if (cmd.sub_en && hit) begin
         seg_in = seg_ff - amt;
      end
      vld_in_nxt   = vld_in;
      found_in_nxt = found_in || take;
      idx_in_nxt   = take ? IDX_W'(CELL_IDX) : idx_in;
      val_in_nxt   = take ? seg_ff : val_in;
      sum_in_nxt   = sum_in + (in_use ? ACC_W'(seg_ff) : '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in_nxt;
      end
      seg_ff   <= seg_in;
      found_ff <= found_in_nxt;
      idx_ff   <= idx_in_nxt;
      val_ff   <= val_in_nxt;
      sum_ff   <= sum_in_nxt;
   end

   assign vld_out   = vld_ff;
   assign found_out = found_ff;
   assign idx_out   = idx_ff;
   assign val_out   = val_ff;
   assign sum_out   = sum_ff;

endmodule
`default_nettype wire

// File: rtl/sfa_chain.sv
// Row of segment cells that the scan record walks through, one cell a cycle.
`timescale 1ns / 1ps
`default_nettype none
module sfa_chain #(
   parameter int SLOTS     = 16,
   parameter int SIZE_BITS = 16,
   parameter int IDX_W     = 4,
   parameter int TGT_W     = 4,
   parameter int CNT_W     = 5,
   parameter int ACC_W     = 21
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire sfa_pkg::cell_cmd_type   cmd,
   input  wire  [TGT_W-1:0]             tgt,
   input  wire  [SIZE_BITS-1:0]         amt,
   input  wire  [sfa_pkg::MODE_W-1:0]   mode,
   input  wire  [CNT_W-1:0]             count,
   input  wire                          launch,
   output logic                         done,
   output logic                         found,
   output logic [IDX_W-1:0]             pick_idx,
   output logic [SIZE_BITS-1:0]         pick_val,
   output logic [ACC_W-1:0]             sum
);
   import sfa_pkg::*;

   logic                 vld_w   [SLOTS+1];
   logic                 found_w [SLOTS+1];
   logic [IDX_W-1:0]     idx_w   [SLOTS+1];
   logic [SIZE_BITS-1:0] val_w   [SLOTS+1];
   logic [ACC_W-1:0]     sum_w   [SLOTS+1];

   // fresh record enters at the head
   assign vld_w[0]   = launch;
   assign found_w[0] = 1'b0;
   assign idx_w[0]   = '0;
   assign val_w[0]   = '0;
   assign sum_w[0]   = '0;

   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      sfa_cell #(
         .SIZE_BITS (SIZE_BITS),
         .IDX_W     (IDX_W),
         .TGT_W     (TGT_W),
         .CNT_W     (CNT_W),
         .ACC_W     (ACC_W),
         .CELL_IDX  (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .tgt       (tgt),
         .amt       (amt),
         .mode      (mode),
         .count     (count),
         .vld_in    (vld_w[i]),
         .found_in  (found_w[i]),
         .idx_in    (idx_w[i]),
         .val_in    (val_w[i]),
         .sum_in    (sum_w[i]),
         .vld_out   (vld_w[i+1]),
         .found_out (found_w[i+1]),
         .idx_out   (idx_w[i+1]),
         .val_out   (val_w[i+1]),
         .sum_out   (sum_w[i+1])
      );
   end

   assign done     = vld_w[SLOTS];
   assign found    = found_w[SLOTS];
   assign pick_idx = idx_w[SLOTS];
   assign pick_val = val_w[SLOTS];
   assign sum      = sum_w[SLOTS];

endmodule
`default_nettype wire

// File: rtl/segment_fit_allocator_top.sv
// Segment fit allocator: top level with sequencer, config registers and output register.
//
// Usage:
//   req_* carries one item: tuser = kind (0 load, 1 allocate), tdata = slot and
//   amount. A load writes a segment's free size; an allocate picks a segment by
//   the fit_mode register (first, best or worst fit, ties to the lowest slot)
//   and shrinks it by the request.
//   rsp_* returns one result per item: tuser = granted, tdata = chosen slot,
//   leftover and the saturated total free size of the slots in use.
//   csr_* writes fit_mode (index 0) or slots_in_use (index 1); write only while
//   no item is in flight.
// Timing:
//   A scan record walks the row of SLOTS cells, one cell per cycle, comparing
//   and summing as it goes. One item is in flight at a time: the next item is
//   taken only after the result of the last is written to the output register.
// Reset: clears control state and loads fit_mode 0, slots_in_use 16. Segment
//   sizes are undefined until loaded.
// Stall: a result waits in the output register while rsp_tready is low; a
//   finished scan holds until the register frees, and no new item is taken.
`timescale 1ns / 1ps
`default_nettype none
module segment_fit_allocator_top #(
   parameter int SLOTS     = 16,
   parameter int SIZE_BITS = 16
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_tvalid,
   output logic                             req_tready,
   // [3:0] slot, [19:4] amount, [23:20] zero
   input  wire  [sfa_pkg::REQ_DATA_W-1:0]   req_tdata,
   // [0] kind
   input  wire                              req_tuser,
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   // [3:0] chosen_slot, [19:4] leftover, [39:20] remaining_total
   output logic [sfa_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // [0] granted
   output logic                             rsp_tuser,
   input  wire                              csr_wen,
   input  wire  [sfa_pkg::ADDR_W-1:0]       csr_addr,
   input  wire  [sfa_pkg::CNT_CFG_W-1:0]    csr_wdata
);
   import sfa_pkg::*;

   localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int TGT_W  = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
   localparam int CNT_W  = $clog2(SLOTS + 1);
   localparam int CMP_W  = (CNT_W > CNT_CFG_W) ? CNT_W : CNT_CFG_W;
   localparam int SUM_W  = SIZE_BITS + $clog2(SLOTS + 1);
   localparam int ACC_W  = (SUM_W > TOTAL_W) ? SUM_W : TOTAL_W + 1;

   state_type state_ff, state_in;

   logic [MODE_W-1:0]    mode_ff, mode_in;
   logic [CNT_CFG_W-1:0] slots_ff, slots_in;
   logic                 kind_ff, kind_in;
   logic [SIZE_BITS-1:0] amt_ff, amt_in;

   logic                 found_ff, found_in;
   logic [IDX_W-1:0]     pick_ff, pick_in;
   logic [SIZE_BITS-1:0] pval_ff, pval_in;
   logic [ACC_W-1:0]     sum_ff, sum_in;

   logic                 rsp_vld_ff, rsp_vld_in;
   logic                 rsp_gnt_ff, rsp_gnt_in;
   logic [SLOT_W-1:0]    rsp_slot_ff, rsp_slot_in;
   logic [AMT_W-1:0]     rsp_left_ff, rsp_left_in;
   logic [TOTAL_W-1:0]   rsp_total_ff, rsp_total_in;

   logic                 accept, out_free, grant, launch, capture, apply;
   logic [CNT_W-1:0]     count;
   logic [SIZE_BITS-1:0] port_amt, bus_amt;
   logic [TGT_W-1:0]     bus_tgt;
   cell_cmd_type         cmd;
   logic                 ch_done, ch_found;
   logic [IDX_W-1:0]     ch_idx;
   logic [SIZE_BITS-1:0] ch_val;
   logic [ACC_W-1:0]     ch_sum;
   logic [ACC_W-1:0]     total_raw;

   assign port_amt = SIZE_BITS'(req_tdata[SLOT_W +: AMT_W]);
   assign accept   = req_tvalid && req_tready;
   assign out_free = !rsp_vld_ff || rsp_tready;
   assign grant    = (kind_ff == KIND_ALLOC) && found_ff;

   // saturate the configured count to the row length
   assign count = (CMP_W'(slots_ff) > CMP_W'(SLOTS)) ? CNT_W'(SLOTS) : CNT_W'(slots_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_tvalid) state_in = ST_LAUNCH;
         ST_LAUNCH: state_in = ST_SCAN;
         ST_SCAN:   if (ch_done) state_in = ST_APPLY;
         ST_APPLY:  if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_tready  = 1'b0;
      launch      = 1'b0;
      capture     = 1'b0;
      apply       = 1'b0;
      cmd.load_en = 1'b0;
      cmd.sub_en  = 1'b0;
      bus_tgt     = TGT_W'(pick_ff);
      bus_amt     = amt_ff;
      case (state_ff)
         ST_IDLE: begin
            req_tready  = 1'b1;
            // write a loaded segment at acceptance so the scan sees it
            cmd.load_en = req_tvalid && (req_tuser == KIND_LOAD);
            bus_tgt     = TGT_W'(req_tdata[SLOT_W-1:0]);
            bus_amt     = port_amt;
         end
         ST_LAUNCH: launch = 1'b1;
         ST_SCAN:   capture = ch_done;
         ST_APPLY: begin
            apply      = out_free;
            cmd.sub_en = out_free && grant;
         end
         default: ;
      endcase
   end

   always_comb begin
      mode_in  = mode_ff;
      slots_in = slots_ff;
      if (csr_wen) begin
         case (csr_addr)
            CSR_FIT_MODE:     mode_in  = csr_wdata[MODE_W-1:0];
            CSR_SLOTS_IN_USE: slots_in = csr_wdata;
            default: ;
         endcase
      end
   end

   assign kind_in  = accept ? req_tuser : kind_ff;
   assign amt_in   = accept ? port_amt : amt_ff;
   assign found_in = capture ? ch_found : found_ff;
   assign pick_in  = capture ? ch_idx : pick_ff;
   assign pval_in  = capture ? ch_val : pval_ff;
   assign sum_in   = capture ? ch_sum : sum_ff;

   // total after the grant, clipped to the field
   assign total_raw = sum_ff - (grant ? ACC_W'(amt_ff) : '0);

   always_comb begin
      rsp_vld_in   = rsp_vld_ff && !rsp_tready;
      rsp_gnt_in   = rsp_gnt_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_left_in  = rsp_left_ff;
      rsp_total_in = rsp_total_ff;
      if (apply) begin
         rsp_vld_in   = 1'b1;
         rsp_gnt_in   = grant;
         rsp_slot_in  = grant ? SLOT_W'(pick_ff) : '0;
         rsp_left_in  = grant ? AMT_W'(pval_ff - amt_ff) : '0;
         rsp_total_in = (total_raw > ACC_W'(TOTAL_MAX)) ? TOTAL_MAX : TOTAL_W'(total_raw);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         mode_ff    <= FIT_FIRST;
         slots_ff   <= SLOTS_IN_USE_RST;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         mode_ff    <= mode_in;
         slots_ff   <= slots_in;
         rsp_vld_ff <= rsp_vld_in;
      end
      kind_ff      <= kind_in;
      amt_ff       <= amt_in;
      found_ff     <= found_in;
      pick_ff      <= pick_in;
      pval_ff      <= pval_in;
      sum_ff       <= sum_in;
      rsp_gnt_ff   <= rsp_gnt_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_left_ff  <= rsp_left_in;
      rsp_total_ff <= rsp_total_in;
   end

   sfa_chain #(
      .SLOTS     (SLOTS),
      .SIZE_BITS (SIZE_BITS),
      .IDX_W     (IDX_W),
      .TGT_W     (TGT_W),
      .CNT_W     (CNT_W),
      .ACC_W     (ACC_W)
   ) u_chain (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .tgt      (bus_tgt),
      .amt      (bus_amt),
      .mode     (mode_ff),
      .count    (count),
      .launch   (launch),
      .done     (ch_done),
      .found    (ch_found),
      .pick_idx (ch_idx),
      .pick_val (ch_val),
      .sum      (ch_sum)
   );

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tuser  = rsp_gnt_ff;
   assign rsp_tdata  = {rsp_total_ff, rsp_left_ff, rsp_slot_ff};

endmodule
`default_nettype wire

// File: rtl/sfa_checker.sv
// Port-level assertions for the segment fit allocator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module sfa_checker (
   input wire                              clock,
   input wire                              reset,
   input wire                              req_tvalid,
   input wire                              req_tready,
   input wire                              rsp_tvalid,
   input wire                              rsp_tready,
   input wire [sfa_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input wire                              rsp_tuser
);
   import sfa_pkg::*;

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   // one item at a time: no acceptance right after one
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("item accepted while another is in flight");

   // a refused request reports neither slot nor leftover
   a_no_grant_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[SLOT_W+AMT_W-1:0] == '0)
      else $error("slot or leftover set without a grant");

   // no result right after reset
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // a result does not rise right after an acceptance
   a_no_early: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !rsp_tvalid || $past(rsp_tvalid) || $stable(rsp_tvalid))
      else $error("result appeared right after acceptance");

endmodule

bind segment_fit_allocator_top sfa_checker u_sfa_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire

// File: tb/tb_segment_fit_allocator_top.sv
// Self-checking testbench for the segment fit allocator: load and allocate items.
`timescale 1ns / 1ps
module tb_segment_fit_allocator_top;
   import sfa_pkg::*;

   localparam int                NSEG       = 16;
   localparam int                IDLE_LIMIT = 3000;
   localparam int                PHASES     = 13;
   localparam int                PHASE_LEN  = 100;
   localparam logic [MODE_W-1:0] FIT_ALIAS  = 2'd3;  // unused code, acts as first fit

   // Tracks segment sizes and registers; predicts one grant record per item.
   class fit_ledger;
      typedef struct packed {
         logic               granted;
         logic [3:0]         slot;
         logic [AMT_W-1:0]   leftover;
         logic [TOTAL_W-1:0] total;
      } grant_type;

      logic [AMT_W-1:0]     seg_size [NSEG];
      logic [MODE_W-1:0]    mode;
      logic [CNT_CFG_W-1:0] span;
      grant_type            due[$];
      int                   errors, n_loads, n_allocs, n_grants, n_waits, n_results;

      function new();
         foreach (seg_size[i]) seg_size[i] = '0;
         mode = FIT_FIRST;
         span = SLOTS_IN_USE_RST;
      endfunction

      function void set_register(logic [ADDR_W-1:0] addr, logic [CNT_CFG_W-1:0] data);
         if (addr == CSR_FIT_MODE) mode = data[MODE_W-1:0];
         else span = data;
      endfunction

      function int active_slots();
         return (span > NSEG) ? NSEG : int'(span);
      endfunction

      function void accept_item(logic kind, logic [3:0] slot, logic [AMT_W-1:0] amount);
         grant_type   r;
         int          n;
         bit          found;
         int          pick;
         longint      acc;
         r = '0;
         if (kind == KIND_LOAD) begin
            seg_size[slot] = amount;
            n_loads++;
         end else begin
            n_allocs++;
            n = active_slots();
            found = 0;
            pick = 0;
            for (int i = 0; i < n; i++) begin
               if (seg_size[i] >= amount) begin
                  if (!found) begin
                     found = 1;
                     pick = i;
                  end else if (mode == FIT_BEST && seg_size[i] < seg_size[pick]) begin
                     pick = i;
                  end else if (mode == FIT_WORST && seg_size[i] > seg_size[pick]) begin
                     pick = i;
                  end
               end
            end
            if (found) begin
               seg_size[pick] = seg_size[pick] - amount;
               r.granted  = 1'b1;
               r.slot     = pick[3:0];
               r.leftover = seg_size[pick];
               n_grants++;
            end else begin
               n_waits++;
            end
         end
         acc = 0;
         for (int i = 0; i < active_slots(); i++) acc += seg_size[i];
         r.total = (acc > TOTAL_MAX) ? TOTAL_MAX : acc[TOTAL_W-1:0];
         due.push_back(r);
      endfunction

      function void check_grant(logic granted, logic [RSP_DATA_W-1:0] data);
         grant_type e;
         n_results++;
         if (due.size() == 0) begin
            $display("%0t ERROR unexpected result: granted %0d data 0x%0h",
                     $time, granted, data);
            errors++;
            return;
         end
         e = due.pop_front();
         if (granted !== e.granted) begin
            $display("%0t ERROR granted: expected %0d actual %0d", $time, e.granted, granted);
            errors++;
         end
         if (data[3:0] !== e.slot) begin
            $display("%0t ERROR chosen_slot: expected %0d actual %0d",
                     $time, e.slot, data[3:0]);
            errors++;
         end
         if (data[19:4] !== e.leftover) begin
            $display("%0t ERROR leftover: expected %0d actual %0d",
                     $time, e.leftover, data[19:4]);
            errors++;
         end
         if (data[39:20] !== e.total) begin
            $display("%0t ERROR remaining_total: expected %0d actual %0d",
                     $time, e.total, data[39:20]);
            errors++;
         end
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [REQ_DATA_W-1:0]    req_tdata;   // [3:0] slot, [19:4] amount, [23:20] zero
   logic                     req_tuser;   // [0] kind
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic [RSP_DATA_W-1:0]    rsp_tdata;   // [3:0] chosen_slot, [19:4] leftover, [39:20] total
   logic                     rsp_tuser;   // [0] granted
   logic                     csr_wen;
   logic [ADDR_W-1:0]        csr_addr;
   logic [CNT_CFG_W-1:0]     csr_wdata;

   fit_ledger sb;
   bit        calm;
   int        gap_pct;
   int        stall_pct;
   int        idle_cycles;
   int        settings_used;

   segment_fit_allocator_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // result side: ready bursts with random stalls, none once calm
   initial begin
      forever begin
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 40)) @(posedge clock);
         if (!calm && $urandom_range(0, 99) < stall_pct) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_grant(rsp_tuser, rsp_tdata);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t ERROR no item moved for %0d cycles", $time, IDLE_LIMIT);
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic write_csr(input logic [ADDR_W-1:0] addr, input logic [CNT_CFG_W-1:0] data);
      csr_wen   <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      @(posedge clock);
      sb.set_register(addr, data);
      csr_wen <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (sb.due.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic configure(input logic [MODE_W-1:0] mode, input logic [CNT_CFG_W-1:0] span);
      logic [2:0] junk;
      junk = 3'($urandom_range(0, 7));
      wait_drained();
      // upper bits of the mode write are don't-care
      write_csr(CSR_FIT_MODE, {junk, mode});
      write_csr(CSR_SLOTS_IN_USE, span);
      settings_used++;
   endtask

   task automatic send_item(input logic kind, input logic [3:0] slot,
                            input logic [AMT_W-1:0] amount);
      if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {4'b0000, amount, slot};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.accept_item(kind, slot, amount);
   endtask

   // aim requests at live segments so most allocations land
   function automatic logic [AMT_W-1:0] pick_request();
      int               n;
      int               idx;
      int               r;
      logic [AMT_W-1:0] top;
      n = sb.active_slots();
      if (n == 0) return AMT_W'($urandom_range(0, 65535));
      idx = $urandom_range(0, n - 1);
      top = '0;
      for (int i = 0; i < n; i++) if (sb.seg_size[i] > top) top = sb.seg_size[i];
      r = $urandom_range(0, 99);
      if (r < 8) return '0;
      if (r < 18) return (top == '1) ? top : top + AMT_W'(1);
      if (r < 35) return sb.seg_size[idx];
      return AMT_W'($urandom_range(0, int'(sb.seg_size[idx])));
   endfunction

   function automatic logic [AMT_W-1:0] pick_load();
      int r;
      r = $urandom_range(0, 99);
      if (r < 35) return AMT_W'($urandom);
      if (r < 60) return AMT_W'($urandom_range(0, 15));   // small values breed ties
      if (r < 70) return '1;
      if (r < 78) return '0;
      return sb.seg_size[$urandom_range(0, NSEG - 1)];
   endfunction

   initial begin
      logic [MODE_W-1:0]    mode;
      logic [CNT_CFG_W-1:0] span;
      int                   r;

      sb = new();
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = KIND_LOAD;
      csr_wen = 1'b0;
      csr_addr = CSR_FIT_MODE;
      csr_wdata = '0;
      calm = 0;
      gap_pct = 25;
      stall_pct = 50;
      settings_used = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // no slot in use yet, so nothing unloaded is ever summed or scanned
      configure(FIT_FIRST, 5'd0);
      send_item(KIND_ALLOC, 4'd0, 16'd5);
      for (int i = 0; i < NSEG; i++) begin
         case (i)
            0, 3: send_item(KIND_LOAD, i[3:0], 16'd100);
            1: send_item(KIND_LOAD, i[3:0], 16'hFFFF);
            2, 5: send_item(KIND_LOAD, i[3:0], 16'd40);
            4: send_item(KIND_LOAD, i[3:0], 16'd0);
            default: send_item(KIND_LOAD, i[3:0], 16'(300 + 37 * i));
         endcase
      end
      configure(FIT_FIRST, 5'd16);
      send_item(KIND_ALLOC, 4'hF, 16'd0);
      send_item(KIND_ALLOC, 4'd0, 16'hFFFF);
      send_item(KIND_ALLOC, 4'd0, 16'hFFFF);
      configure(FIT_BEST, 5'd16);
      send_item(KIND_ALLOC, 4'd0, 16'd40);
      configure(FIT_WORST, 5'd16);
      send_item(KIND_ALLOC, 4'd0, 16'd10);
      configure(FIT_ALIAS, 5'd16);
      send_item(KIND_ALLOC, 4'd0, 16'd50);

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: begin mode = FIT_FIRST; span = 5'd16; end
            1: begin mode = FIT_BEST;  span = 5'd16; end
            2: begin mode = FIT_WORST; span = 5'd16; end
            3: begin mode = FIT_ALIAS; span = 5'd31; end
            4: begin mode = FIT_BEST;  span = 5'd1;  end
            5: begin mode = FIT_WORST; span = 5'd0;  end
            6: begin mode = FIT_FIRST; span = 5'd20; end
            default: begin
               mode = MODE_W'($urandom_range(0, 3));
               r = $urandom_range(0, 99);
               if (r < 10) span = 5'd0;
               else if (r < 20) span = 5'd1;
               else if (r < 40) span = 5'd16;
               else if (r < 50) span = 5'($urandom_range(17, 31));
               else span = 5'($urandom_range(2, 15));
            end
         endcase
         configure(mode, span);
         calm = (p == PHASES - 1);
         r = $urandom_range(0, 2);
         gap_pct   = calm ? 0 : (r == 0) ? 0 : (r == 1) ? 10 : 35;
         stall_pct = calm ? 0 : (r == 2) ? 20 : 60;
         for (int k = 0; k < PHASE_LEN; k++) begin
            if ($urandom_range(0, 99) < 35) begin
               send_item(KIND_LOAD, 4'($urandom_range(0, 15)), pick_load());
            end else begin
               send_item(KIND_ALLOC, 4'($urandom_range(0, 15)), pick_request());
            end
         end
      end

      wait_drained();
      repeat (30) @(posedge clock);
      $display("Ran %0d items: %0d loads, %0d allocations (%0d granted, %0d waiting)",
               sb.n_loads + sb.n_allocs, sb.n_loads, sb.n_allocs, sb.n_grants, sb.n_waits);
      $display("Checked %0d results across %0d register settings, %0d mismatches",
               sb.n_results, settings_used, sb.errors);
      if (sb.errors == 0 && sb.due.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/sfa_pkg.sv
rtl/sfa_cell.sv
rtl/sfa_chain.sv
rtl/segment_fit_allocator_top.sv
rtl/sfa_checker.sv
tb/tb_segment_fit_allocator_top.sv
